// ===== rtl/core/ifb_pkg.sv =====
// Shared types, codes and constants for the indexed framebuffer fill/blit block.
package ifb_pkg;

  localparam int DIM_W      = 11;
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 4;
  localparam int FP_W       = 32;
  localparam int KEY_W      = 5;
  localparam int PIX_W      = 8;
  localparam int FILLC_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CHECKER_BIT = 15;
  localparam int FRAME_DEPTH_DEF = 65536;
  localparam int MAX_DIM_DEF     = 1024;

  localparam logic [FILLC_W-1:0] COLOR_MAX = 16'd15;
  localparam logic signed [KEY_W-1:0] KEY_NONE = -5'sd1;

  typedef enum logic [2:0] {
    ACT_FILL_ALL  = 3'd0,
    ACT_FILL_BOX  = 3'd1,
    ACT_BLIT_START = 3'd2,
    ACT_BLIT_PIXEL = 3'd3,
    ACT_READ_PIXEL = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_LINE_PITCH    = 3'd2,
    REG_PALETTE_FP    = 3'd3,
    REG_FRAME_FP      = 3'd4,
    REG_FRAME_VERIFIED = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ
  } state_t;

endpackage

// ===== rtl/core/ifb_mem.sv =====
// Frame store: one write port, one read port with registered read data.
module ifb_mem #(
  parameter int DEPTH = ifb_pkg::FRAME_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [ifb_pkg::COLOR_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [ifb_pkg::COLOR_W-1:0]  rdata
);
  import ifb_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ifb_addr.sv =====
// Pixel address generator: y * pitch + x with a range check against the store depth.
module ifb_addr #(
  parameter int DEPTH = ifb_pkg::FRAME_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic [ifb_pkg::DIM_W-1:0] x,
  input  logic [ifb_pkg::DIM_W-1:0] y,
  input  logic [ifb_pkg::DIM_W-1:0] pitch,
  output logic [AW-1:0]             addr,
  output logic                      in_range
);
  import ifb_pkg::*;

  localparam int SUM_W = 2 * DIM_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_W = SUM_W'(DEPTH);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum      = SUM_W'(y * pitch) + SUM_W'(x);
    in_range = sum < DEPTH_W;
    addr     = sum[AW-1:0];
  end

endmodule

// ===== rtl/core/indexed_framebuffer_fill_blit.sv =====
// Top level of the indexed framebuffer fill/blit engine.
//
// The block owns a 4-bit indexed frame store (FRAME_DEPTH entries, row-major at
// y * line_pitch + x) and takes one request at a time on the req channel; each
// request yields exactly one response on the rsp channel. Blit-start,
// blit-pixel and rejected requests are answered when taken. A read-pixel
// addresses the store when taken, then returns the registered read data. A
// fill walks its clipped rectangle (width times height for fill-all) one
// pixel per cycle, row by row, through the single write port of the store;
// its response is posted at once, and the next request is taken when the
// walk ends. A waiting response holds off the next request until it is
// taken; the response register is refilled in the cycle it is taken, so a
// taken response costs no gap. Configuration writes are registered and are
// to be made only while the block is idle. Stored pixels are undefined until
// written; there is no clearing pass after reset.
module indexed_framebuffer_fill_blit #(
  parameter int FRAME_DEPTH = ifb_pkg::FRAME_DEPTH_DEF,
  parameter int MAX_DIM     = ifb_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [ifb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ifb_pkg::FP_W-1:0]           cfg_data,
  // request channel
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [2:0]                         action,
  input  logic [ifb_pkg::FILLC_W-1:0]        color,
  input  logic signed [ifb_pkg::COORD_W-1:0] box_left,
  input  logic signed [ifb_pkg::COORD_W-1:0] box_right,
  input  logic signed [ifb_pkg::COORD_W-1:0] box_top,
  input  logic signed [ifb_pkg::COORD_W-1:0] box_bottom,
  input  logic [ifb_pkg::DIM_W-1:0]          src_width,
  input  logic [ifb_pkg::DIM_W-1:0]          src_height,
  input  logic [ifb_pkg::FP_W-1:0]           src_palette_fp,
  input  logic signed [ifb_pkg::KEY_W-1:0]   transparent,
  input  logic [ifb_pkg::PIX_W-1:0]          pixel,
  // response channel
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               status,
  output logic [ifb_pkg::COLOR_W-1:0]        read_color,
  output logic                               blit_done
);
  import ifb_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int MD_W = DIM_W + 2;
  localparam logic [MD_W-1:0] MAX_DIM_W = MD_W'(MAX_DIM);
  localparam int PROD_W = 2 * DIM_W;
  localparam logic [PROD_W:0] DEPTH_P = (PROD_W + 1)'(FRAME_DEPTH);

  // configuration registers
  logic [DIM_W-1:0] frame_width, frame_height, line_pitch;
  logic [FP_W-1:0]  bound_pal_fp, frame_fingerprint;
  logic             frame_verified;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width         <= DIM_W'(320);
      frame_height        <= DIM_W'(200);
      line_pitch          <= DIM_W'(320);
      bound_pal_fp        <= '0;
      frame_fingerprint   <= '0;
      frame_verified      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width         <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height        <= cfg_data[DIM_W-1:0];
        REG_LINE_PITCH:     line_pitch          <= cfg_data[DIM_W-1:0];
        REG_PALETTE_FP:     bound_pal_fp        <= cfg_data;
        REG_FRAME_FP:       frame_fingerprint   <= cfg_data;
        REG_FRAME_VERIFIED: frame_verified      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // configuration check: dimensions, pitch, area against the store, identity
  logic cfg_ok;
  always_comb begin
    cfg_ok = (frame_width != '0) && (MD_W'(frame_width) <= MAX_DIM_W)
          && (frame_height != '0) && (MD_W'(frame_height) <= MAX_DIM_W)
          && (line_pitch >= frame_width)
          && ((PROD_W + 1)'(frame_height * line_pitch) <= DEPTH_P)
          && frame_verified && (frame_fingerprint != '0) && (bound_pal_fp != '0);
  end

  // control and blit state
  state_t state, state_next;
  logic   blit_active;
  logic [DIM_W-1:0] blit_col, blit_row, blit_width, blit_height;
  logic signed [COORD_W-1:0] blit_origin_x, blit_origin_y;
  logic signed [KEY_W-1:0]   blit_key;

  // fill walker
  logic [DIM_W-1:0] cur_x, cur_y, x_lo, x_hi, y_hi;
  logic [COLOR_W-1:0] paint_color;
  logic fill_checker, fill_par;

  logic rd_range;

  logic accept, rsp_free;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign accept    = req_valid && req_ready;

  // request decode
  logic signed [COORD_W:0] fw_s, fh_s;
  logic fill_all_ok, box_order_ok, box_hit, start_ok;
  logic signed [COORD_W:0] tx, ty;
  logic on_frame, pix_bad, keyed, col_last, row_last, read_inside;
  logic [DIM_W-1:0] clip_l, clip_r, clip_b;

  always_comb begin
    fw_s = $signed({6'b0, frame_width});
    fh_s = $signed({6'b0, frame_height});
    fill_all_ok  = color <= COLOR_MAX;
    box_order_ok = (box_left <= box_right) && (box_top <= box_bottom);
    box_hit = (box_right >= 0) && (box_bottom >= 0)
           && (COORD_W+1)'(box_left) < fw_s && (COORD_W+1)'(box_top) < fh_s;
    clip_l = (box_left < 0) ? '0 : box_left[DIM_W-1:0];
    clip_r = ((COORD_W+1)'(box_right) >= fw_s) ? frame_width - 1'b1
                                               : box_right[DIM_W-1:0];
    clip_b = ((COORD_W+1)'(box_bottom) >= fh_s) ? frame_height - 1'b1
                                                : box_bottom[DIM_W-1:0];
    start_ok = (src_width != '0) && (src_height != '0)
            && (MD_W'(src_width) <= MAX_DIM_W) && (MD_W'(src_height) <= MAX_DIM_W)
            && (src_palette_fp != '0) && (src_palette_fp == bound_pal_fp)
            && (transparent >= KEY_NONE);
    tx = (COORD_W+1)'(blit_origin_x) + $signed({6'b0, blit_col});
    ty = (COORD_W+1)'(blit_origin_y) + $signed({6'b0, blit_row});
    on_frame = (tx >= 0) && (ty >= 0) && (tx < fw_s) && (ty < fh_s);
    pix_bad = pixel > PIX_W'(COLOR_MAX);
    keyed   = (blit_key >= 0) && (pixel == PIX_W'(blit_key[COLOR_W-1:0]));
    col_last = (blit_col + 1'b1) >= blit_width;
    row_last = (blit_row + 1'b1) >= blit_height;
    read_inside = (box_left >= 0) && (box_top >= 0)
               && (COORD_W+1)'(box_left) < fw_s && (COORD_W+1)'(box_top) < fh_s;
  end

  // address and store
  logic [DIM_W-1:0] ax, ay;
  logic [AW-1:0]    addr;
  logic             addr_ok;
  logic             mem_we;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;
  logic             fill_skip;

  always_comb begin
    if (state == S_FILL) begin
      ax = cur_x;
      ay = cur_y;
    end else if (action == ACT_READ_PIXEL) begin
      ax = box_left[DIM_W-1:0];
      ay = box_top[DIM_W-1:0];
    end else begin
      ax = tx[DIM_W-1:0];
      ay = ty[DIM_W-1:0];
    end
    fill_skip = fill_checker && (cur_x[0] ^ cur_y[0] ^ fill_par);
    if (state == S_FILL) begin
      mem_we    = !fill_skip && addr_ok;
      mem_wdata = paint_color;
    end else begin
      mem_we    = accept && cfg_ok && (action == ACT_BLIT_PIXEL) && blit_active
               && on_frame && !pix_bad && !keyed && addr_ok;
      mem_wdata = pixel[COLOR_W-1:0];
    end
  end

  ifb_addr #(.DEPTH(FRAME_DEPTH), .AW(AW)) u_addr (
    .x(ax), .y(ay), .pitch(line_pitch), .addr(addr), .in_range(addr_ok)
  );

  ifb_mem #(.DEPTH(FRAME_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(addr), .wdata(mem_wdata),
    .raddr(addr), .rdata(mem_rdata)
  );

  // next state
  logic fill_end;
  always_comb begin
    fill_end   = (cur_x == x_hi) && (cur_y == y_hi);
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cfg_ok) begin
          if (action == ACT_FILL_ALL && fill_all_ok) begin
            state_next = S_FILL;
          end else if (action == ACT_FILL_BOX && box_order_ok && box_hit) begin
            state_next = S_FILL;
          end else if (action == ACT_READ_PIXEL && read_inside) begin
            state_next = S_READ;
          end
        end
      end
      S_FILL: begin
        if (fill_end) begin
          state_next = S_IDLE;
        end
      end
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fill walker: load on a fill request, advance one pixel a cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rd_range <= addr_ok;
      if (action == ACT_FILL_ALL) begin
        cur_x <= '0;
        cur_y <= '0;
        x_lo  <= '0;
        x_hi  <= frame_width - 1'b1;
        y_hi  <= frame_height - 1'b1;
        fill_checker <= 1'b0;
      end else begin
        cur_x <= clip_l;
        cur_y <= (box_top < 0) ? '0 : box_top[DIM_W-1:0];
        x_lo  <= clip_l;
        x_hi  <= clip_r;
        y_hi  <= clip_b;
        fill_checker <= color[CHECKER_BIT];
      end
      paint_color <= color[COLOR_W-1:0];
      fill_par    <= box_left[0] ^ box_top[0];
    end else if (state == S_FILL) begin
      if (cur_x == x_hi) begin
        cur_x <= x_lo;
        cur_y <= cur_y + 1'b1;
      end else begin
        cur_x <= cur_x + 1'b1;
      end
    end
  end

  // blit state
  always_ff @(posedge clk) begin
    if (rst) begin
      blit_active   <= 1'b0;
      blit_col      <= '0;
      blit_row      <= '0;
      blit_width    <= '0;
      blit_height   <= '0;
      blit_origin_x <= '0;
      blit_origin_y <= '0;
      blit_key      <= KEY_NONE;
    end else if (accept) begin
      if (!cfg_ok) begin
        if (action == ACT_BLIT_PIXEL) begin
          blit_active <= 1'b0;
        end
      end else if (action == ACT_BLIT_START) begin
        blit_active <= start_ok;
        if (start_ok) begin
          blit_col      <= '0;
          blit_row      <= '0;
          blit_width    <= src_width;
          blit_height   <= src_height;
          blit_origin_x <= box_left;
          blit_origin_y <= box_top;
          blit_key      <= transparent;
        end
      end else if (action == ACT_BLIT_PIXEL && blit_active) begin
        if (on_frame && pix_bad) begin
          blit_active <= 1'b0;
        end else if (col_last) begin
          blit_col <= '0;
          if (row_last) begin
            blit_row    <= '0;
            blit_active <= 1'b0;
          end else begin
            blit_row <= blit_row + 1'b1;
          end
        end else begin
          blit_col <= blit_col + 1'b1;
        end
      end
    end
  end

  // response register: post at accept, or after the read data returns
  logic post_now, post_status, post_done;
  always_comb begin
    post_now    = accept && !(cfg_ok && action == ACT_READ_PIXEL && read_inside);
    post_status = 1'b1;
    post_done   = 1'b0;
    if (cfg_ok) begin
      case (action)
        ACT_FILL_ALL:   post_status = !fill_all_ok;
        ACT_FILL_BOX:   post_status = !box_order_ok;
        ACT_BLIT_START: post_status = !start_ok;
        ACT_BLIT_PIXEL: begin
          post_status = !(blit_active && !(on_frame && pix_bad));
          post_done   = !post_status && col_last && row_last;
        end
        default:        post_status = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (post_now || state == S_READ) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      status     <= 1'b0;
      read_color <= rd_range ? mem_rdata : '0;
      blit_done  <= 1'b0;
    end else if (post_now) begin
      status     <= post_status;
      read_color <= '0;
      blit_done  <= post_done;
    end
  end

endmodule

// ===== tb/sv/indexed_framebuffer_fill_blit_test.sv =====
// Testbench for the indexed framebuffer fill/blit engine: scoreboard model plus requests.
`timescale 1ns / 100ps

module indexed_framebuffer_fill_blit_test;
  import ifb_pkg::*;

  localparam int STORE_DEPTH = FRAME_DEPTH_DEF;
  localparam int DIM_LIMIT   = MAX_DIM_DEF;
  // Action codes the block does not define.
  localparam logic [2:0] ACT_UNDEF_LO  = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI  = 3'd7;
  localparam int RANDOM_TOTAL = 1150;

  typedef struct packed {
    logic [2:0]                 action;
    logic [FILLC_W-1:0]         color;
    logic signed [COORD_W-1:0]  left;
    logic signed [COORD_W-1:0]  right;
    logic signed [COORD_W-1:0]  top;
    logic signed [COORD_W-1:0]  bottom;
    logic [DIM_W-1:0]           sw;
    logic [DIM_W-1:0]           sh;
    logic [FP_W-1:0]            pfp;
    logic signed [KEY_W-1:0]    key;
    logic [PIX_W-1:0]           pix;
  } request_t;

  typedef struct packed {
    logic               status;
    logic [COLOR_W-1:0] rc;
    logic               done;
  } response_t;

  // Framebuffer model and expected-response store.
  class framebuffer_scoreboard;
    logic [COLOR_W-1:0] pixels [STORE_DEPTH];
    int fw, fh, lp;
    logic [FP_W-1:0] pal_fp, frm_fp;
    bit verified;
    bit blit_on;
    int blit_col, blit_row, blit_w, blit_h, blit_x, blit_y, blit_key;
    response_t pending [$];
    int errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      fw = 320; fh = 200; lp = 320;
      pal_fp = '0; frm_fp = '0; verified = 0;
      blit_on = 0; blit_col = 0; blit_row = 0; blit_w = 0; blit_h = 0;
      blit_x = 0; blit_y = 0; blit_key = -1;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [FP_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:    fw = int'(v[DIM_W-1:0]);
        REG_FRAME_HEIGHT:   fh = int'(v[DIM_W-1:0]);
        REG_LINE_PITCH:     lp = int'(v[DIM_W-1:0]);
        REG_PALETTE_FP:     pal_fp = v;
        REG_FRAME_FP:       frm_fp = v;
        REG_FRAME_VERIFIED: verified = v[0];
        default: ;
      endcase
    endfunction

    function bit config_ok();
      if (fw < 1 || fw > DIM_LIMIT || fh < 1 || fh > DIM_LIMIT) return 0;
      if (lp < fw || fh * lp > STORE_DEPTH) return 0;
      return verified && frm_fp != 0 && pal_fp != 0;
    endfunction

    // Longest fill walk the current settings allow.
    function int fill_span();
      return config_ok() ? fw * fh : 0;
    endfunction

    function void paint(int x, int y, logic [COLOR_W-1:0] c);
      int a;
      a = y * lp + x;
      if (a < STORE_DEPTH) pixels[a] = c;
    endfunction

    function bit bool_in_frame(int x, int y);
      return x >= 0 && y >= 0 && x < fw && y < fh;
    endfunction

    function void note_request(request_t r);
      response_t e;
      int l, rt, t, b, cl, cr, ct, cb, tx, ty, a;
      bit in_frame;
      e = '{status: 1'b1, rc: '0, done: 1'b0};
      l = int'(r.left); rt = int'(r.right); t = int'(r.top); b = int'(r.bottom);
      if (!config_ok()) begin
        if (r.action == ACT_BLIT_PIXEL) blit_on = 0;
      end else begin
        case (r.action)
          ACT_FILL_ALL: begin
            if (r.color <= COLOR_MAX) begin
              for (int y = 0; y < fh; y++)
                for (int x = 0; x < fw; x++) paint(x, y, r.color[COLOR_W-1:0]);
              e.status = 1'b0;
            end
          end
          ACT_FILL_BOX: begin
            if (l <= rt && t <= b) begin
              e.status = 1'b0;
              if (rt >= 0 && b >= 0 && l < fw && t < fh) begin
                cl = l < 0 ? 0 : l;
                ct = t < 0 ? 0 : t;
                cr = rt >= fw ? fw - 1 : rt;
                cb = b >= fh ? fh - 1 : b;
                for (int y = ct; y <= cb; y++)
                  for (int x = cl; x <= cr; x++)
                    // checkerboard is anchored at the unclipped corner
                    if (!(r.color[CHECKER_BIT] && (((x - l) + (y - t)) & 1)))
                      paint(x, y, r.color[COLOR_W-1:0]);
              end
            end
          end
          ACT_BLIT_START: begin
            if (r.sw == 0 || r.sh == 0 || r.sw > DIM_LIMIT || r.sh > DIM_LIMIT ||
                r.pfp == 0 || r.pfp != pal_fp || int'(r.key) < -1) begin
              blit_on = 0;
            end else begin
              blit_on = 1; blit_col = 0; blit_row = 0;
              blit_w = int'(r.sw); blit_h = int'(r.sh); blit_x = l; blit_y = t;
              blit_key = int'(r.key);
              e.status = 1'b0;
            end
          end
          ACT_BLIT_PIXEL: begin
            if (blit_on) begin
              tx = blit_x + blit_col;
              ty = blit_y + blit_row;
              in_frame = bool_in_frame(tx, ty);
              if (in_frame && r.pix > 15) begin
                blit_on = 0;
              end else begin
                if (in_frame && !(blit_key >= 0 && int'(r.pix) == blit_key))
                  paint(tx, ty, r.pix[COLOR_W-1:0]);
                e.status = 1'b0;
                blit_col++;
                if (blit_col >= blit_w) begin
                  blit_col = 0;
                  blit_row++;
                  if (blit_row >= blit_h) begin
                    blit_row = 0; blit_on = 0; e.done = 1'b1;
                  end
                end
              end
            end
          end
          ACT_READ_PIXEL: begin
            if (bool_in_frame(l, t)) begin
              a = t * lp + l;
              e.rc = a < STORE_DEPTH ? pixels[a] : '0;
              e.status = 1'b0;
            end
          end
          default: ;
        endcase
      end
      pending.push_back(e);
    endfunction

    function void check_response(response_t got);
      response_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: status=%0d read_color=%0d blit_done=%0d",
                   got.status, got.rc, got.done);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: status exp %0d got %0d, read_color exp %0d got %0d,",
                    " blit_done exp %0d got %0d"},
                   e.status, got.status, e.rc, got.rc, e.done, got.done);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FP_W-1:0] cfg_data = '0;
  logic req_valid = 0;
  logic req_ready;
  logic [2:0] action = '0;
  logic [FILLC_W-1:0] color = '0;
  logic signed [COORD_W-1:0] box_left = '0, box_right = '0, box_top = '0, box_bottom = '0;
  logic [DIM_W-1:0] src_width = '0, src_height = '0;
  logic [FP_W-1:0] src_palette_fp = '0;
  logic signed [KEY_W-1:0] transparent = '0;
  logic [PIX_W-1:0] pixel = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  logic status;
  logic [COLOR_W-1:0] read_color;
  logic blit_done;

  framebuffer_scoreboard sb = new();

  int send_idle = 11;
  int recv_idle = 84;
  bit random_on = 0;
  int random_sent = 0;

  indexed_framebuffer_fill_blit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready),
    .action(action), .color(color),
    .box_left(box_left), .box_right(box_right), .box_top(box_top),
    .box_bottom(box_bottom), .src_width(src_width), .src_height(src_height),
    .src_palette_fp(src_palette_fp), .transparent(transparent), .pixel(pixel),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .read_color(read_color), .blit_done(blit_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("indexed_framebuffer_fill_blit_test: FAIL");
    $finish;
  end

  // Response side: check each accepted response, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_response('{status: status, rc: read_color, done: blit_done});
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Issue one request and hold it until the block takes it.
  task automatic send(request_t r);
    if (random_on) begin
      // receiver mostly idle, then the sender mostly idle, then no idling
      case (random_sent * 3 / RANDOM_TOTAL)
        0: begin send_idle = 11; recv_idle = 84; end
        1: begin send_idle = 84; recv_idle = 11; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      random_sent++;
    end
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1;
    action <= r.action; color <= r.color;
    box_left <= r.left; box_right <= r.right; box_top <= r.top; box_bottom <= r.bottom;
    src_width <= r.sw; src_height <= r.sh; src_palette_fp <= r.pfp;
    transparent <= r.key; pixel <= r.pix;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  function automatic request_t blank(logic [2:0] act);
    request_t r;
    r = '0;
    r.action = act;
    r.key = KEY_NONE;
    return r;
  endfunction

  function automatic request_t read_at(int x, int y);
    request_t r;
    r = blank(ACT_READ_PIXEL);
    r.left = COORD_W'(x); r.top = COORD_W'(y);
    return r;
  endfunction

  function automatic request_t box(int l, int rt, int t, int b, int c);
    request_t r;
    r = blank(ACT_FILL_BOX);
    r.left = COORD_W'(l); r.right = COORD_W'(rt);
    r.top = COORD_W'(t); r.bottom = COORD_W'(b);
    r.color = FILLC_W'(c);
    return r;
  endfunction

  function automatic request_t blit_start(int x, int y, int w, int h,
                                          logic [FP_W-1:0] fp, int key);
    request_t r;
    r = blank(ACT_BLIT_START);
    r.left = COORD_W'(x); r.top = COORD_W'(y);
    r.sw = DIM_W'(w); r.sh = DIM_W'(h); r.pfp = fp; r.key = KEY_W'(key);
    return r;
  endfunction

  function automatic request_t blit_px(int p);
    request_t r;
    r = blank(ACT_BLIT_PIXEL);
    r.pix = PIX_W'(p);
    return r;
  endfunction

  function automatic request_t fill_all(int c);
    request_t r;
    r = blank(ACT_FILL_ALL);
    r.color = FILLC_W'(c);
    return r;
  endfunction

  // Drop the request line, wait out every response, then any fill walk still running.
  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (sb.fill_span() + 16) @(posedge clk);
  endtask

  // Write all registers back to back while the block is idle.
  task automatic configure(int w, int h, int p, logic [FP_W-1:0] pf,
                           logic [FP_W-1:0] ff, bit v);
    logic [FP_W-1:0] vals [6];
    cfg_reg_t idx;
    drain();
    vals = '{w, h, p, pf, ff, FP_W'(v)};
    idx = REG_FRAME_WIDTH;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1; cfg_index <= idx; cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
      idx = idx.next();
    end
    cfg_we <= 0;
  endtask

  // One blit: a start, then its whole source stream with occasional
  // bad pixels and reads mixed in.
  task automatic blit_sequence(inout int count);
    int w, h, key;
    w = $urandom_range(1, 5);
    h = $urandom_range(1, 4);
    key = ($urandom_range(3) == 0) ? -1 : $urandom_range(0, 15);
    send(blit_start(int'($urandom_range(0, sb.fw + 4)) - 3,
                    int'($urandom_range(0, sb.fh + 3)) - 2, w, h, sb.pal_fp, key));
    count++;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(14) == 0) begin
        send(read_at($urandom_range(0, sb.fw - 1), $urandom_range(0, sb.fh - 1)));
        count++;
      end
      if ($urandom_range(39) == 0) send(blit_px($urandom_range(16, 255)));
      else if (key >= 0 && $urandom_range(4) == 0) send(blit_px(key));
      else send(blit_px($urandom_range(0, 15)));
      count++;
    end
  endtask

  task automatic random_requests(int n, bit noise, bit big_fills, int span);
    int count, k, l, t;
    request_t r;
    count = 0;
    while (count < n) begin
      k = $urandom_range(99);
      if (k < 30) begin
        blit_sequence(count);
        continue;
      end
      if (k < 50) begin
        l = int'($urandom_range(0, sb.fw + 6)) - 3;
        t = int'($urandom_range(0, sb.fh + 6)) - 3;
        r = box(l, l + $urandom_range(0, span), t, t + $urandom_range(0, span),
                $urandom_range(0, 16'hFFFF));
        // a few out-of-order boxes
        if ($urandom_range(9) == 0) r.right = COORD_W'(l - 1);
        else if ($urandom_range(9) == 0) r.bottom = COORD_W'(t - 1);
      end else if (k < 75 || (k < 80 && !big_fills)) begin
        r = read_at(int'($urandom_range(0, sb.fw + 3)) - 2,
                    int'($urandom_range(0, sb.fh + 3)) - 2);
      end else if (k < 80) begin
        r = fill_all($urandom_range(3) == 0 ? $urandom_range(0, 16'hFFFF)
                                            : $urandom_range(0, 15));
      end else if (k < 88) begin
        r = blit_px($urandom_range(0, 255));
      end else if (k < 94 || !noise) begin
        r = blit_start($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                       $urandom_range(0, 2047), $urandom_range(0, 2047),
                       ($urandom_range(1) == 0) ? sb.pal_fp : $urandom,
                       int'($urandom_range(0, 31)) - 16);
      end else begin
        // fully random fields, any action code
        r.action = 3'($urandom_range(0, 7));
        r.color = FILLC_W'($urandom); r.left = COORD_W'($urandom);
        r.right = COORD_W'($urandom); r.top = COORD_W'($urandom);
        r.bottom = COORD_W'($urandom); r.sw = DIM_W'($urandom);
        r.sh = DIM_W'($urandom); r.pfp = $urandom; r.key = KEY_W'($urandom);
        r.pix = PIX_W'($urandom);
      end
      send(r);
      count++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;

    // Reset configuration is invalid: everything is rejected.
    random_requests(15, 0, 1, 3);

    configure(16, 8, 20, 32'hA5A5_0001, 32'h1, 1);
    // Directed: every action, its extremes and special cases.
    send(fill_all(0));
    send(fill_all(COLOR_MAX));
    send(fill_all(16));
    send(fill_all(16'hFFFF));
    send(box(-32768, 32767, -32768, 32767, 16'h7FF9));
    send(box(-1, 5, -2, 3, 16'h8007));
    send(box(100, 200, 0, 3, 16'h0002));
    send(box(5, 4, 0, 3, 16'h0002));
    send(box(0, 3, 3, 2, 16'h0002));
    send(read_at(0, 0));
    send(read_at(15, 7));
    send(read_at(1, 0));
    send(read_at(-1, 0));
    send(read_at(16, 0));
    send(read_at(0, 8));
    send(read_at(32767, -32768));
    send(blit_px(4));
    send(blit_start(0, 0, 0, 1, 32'hA5A5_0001, -1));
    send(blit_start(0, 0, 1025, 1, 32'hA5A5_0001, -1));
    send(blit_start(0, 0, 1, 2047, 32'hA5A5_0001, -1));
    send(blit_start(0, 0, 1, 1, 32'h0, -1));
    send(blit_start(0, 0, 1, 1, 32'hA5A5_0002, -1));
    send(blit_start(0, 0, 1, 1, 32'hA5A5_0001, -2));
    send(blit_start(0, 0, 1, 1, 32'hA5A5_0001, -16));
    send(blit_start(0, 0, 1024, 1024, 32'hA5A5_0001, 15));
    send(blit_px(15));
    // keyed corner pixel, then three clipped ones ending the blit
    send(blit_start(15, 7, 2, 2, 32'hA5A5_0001, 3));
    send(blit_px(3));
    send(blit_px(200));
    send(blit_px(255));
    send(blit_px(128));
    send(read_at(15, 7));
    send(blit_start(0, 0, 1, 3, 32'hA5A5_0001, -1));
    send(blit_px(5));
    send(read_at(0, 0));
    send(blit_px(16));
    send(blit_px(1));
    send(read_at(0, 1));
    send(blank(ACT_UNDEF_LO));
    send(blank(ACT_UNDEF_MID));
    send(blank(ACT_UNDEF_HI));

    random_on = 1;
    random_requests(600, 1, 1, 8);

    configure(1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send(fill_all(7));
    random_requests(110, 1, 1, 2);

    configure(5, 7, 9, 32'h0000_0001, 32'h8000_0000, 1);
    send(fill_all(12));
    random_requests(260, 1, 1, 6);

    // Widest frame: one whole-frame fill, then short box fills and no further whole-frame fills.
    configure(1024, 64, 1024, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 1);
    send(fill_all(3));
    random_requests(40, 0, 0, 6);

    // Tallest frame.
    configure(32, 1024, 64, 32'h1234_5678, 32'h9ABC_DEF0, 1);
    send(fill_all(10));
    random_requests(40, 0, 0, 6);
    // leave a blit running so the next blit-pixel under a bad setting ends it
    send(blit_start(0, 0, 4, 4, 32'h1234_5678, -1));

    // Invalid settings.
    configure(16, 8, 15, 32'h1, 32'h1, 1);
    send(blit_px(1));
    random_requests(15, 0, 1, 3);
    configure(16, 100, 1024, 32'h1, 32'h1, 1);
    random_requests(15, 0, 1, 3);
    configure(16, 8, 16, 32'h1, 32'h0, 1);
    random_requests(15, 0, 1, 3);
    configure(0, 2047, 2047, 32'h0, 32'h1, 0);
    random_requests(15, 0, 1, 3);

    configure(16, 8, 16, 32'h3, 32'h7, 1);
    send(fill_all(1));
    send(blit_px(2));
    random_requests(60, 1, 1, 8);

    req_valid <= 0;
    drain();
    sb.errors += sb.pending.size();
    if (sb.errors == 0) begin
      $display("indexed_framebuffer_fill_blit_test: PASS");
    end else begin
      $display("indexed_framebuffer_fill_blit_test: FAIL");
    end
    $finish;
  end

endmodule
